### sv/swqt_pkg.sv
// Shared operation and status codes for the semaphore wait queue table.
package swqt_pkg;

  localparam logic [1:0] OP_BLOCK   = 2'd0;
  localparam logic [1:0] OP_UNBLOCK = 2'd1;
  localparam logic [1:0] OP_OUT     = 2'd2;
  localparam logic [1:0] OP_HEAD    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOTFND  = 2'd1;
  localparam logic [1:0] ST_NOFREE  = 2'd2;
  localparam logic [1:0] ST_BLOCKED = 2'd3;

  localparam int KEY_W = 31;
  localparam int PID_W = 4;

endpackage

### sv/semaphore_wait_queue_table.sv
// Semaphore wait queue table: active semaphores keyed by address, FIFO of waiters each.
// Block, unblock and head scan the key memory one slot a cycle, then form the result;
// an unblock that leaves waiters also fetches the new head's link before out_valid rises.
// Out takes its slot from the process table and, unless refused early, walks the queue.
// One operation at a time: busy drops as out_valid rises, so the next beat may follow then.
// Reset clears the slot valid and waiting bits; the memories need no clearing pass.
module semaphore_wait_queue_table #(
  parameter int NUM_PROCS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic [swqt_pkg::KEY_W-1:0]  in_sem_key,
  input  logic [swqt_pkg::PID_W-1:0]  in_process_id,
  output logic                        out_valid,
  output logic [swqt_pkg::PID_W-1:0]  out_result_process,
  output logic [1:0]                  out_status
);

  localparam int IW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int PW = swqt_pkg::PID_W;
  localparam int KW = swqt_pkg::KEY_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_WWAIT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // Per-slot and per-process stores.
  logic [KW-1:0] key_mem   [NUM_PROCS];
  logic [IW-1:0] first_mem [NUM_PROCS];
  logic [IW-1:0] last_mem  [NUM_PROCS];
  logic [IW-1:0] link_mem  [NUM_PROCS];
  logic [IW-1:0] pslot_mem [NUM_PROCS];
  logic [NUM_PROCS-1:0] slot_valid_r, proc_wait_r;

  logic [2:0]    state_r;
  logic [1:0]    op_r;
  logic [KW-1:0] key_r;
  logic [PW-1:0] pid_r;
  logic [IW-1:0] pidx_r, slot_r, cur_r, prev_r, first_r, last_r;
  logic [IW:0]   scan_r;
  logic          hit_r, free_found_r;
  logic [IW-1:0] free_r;
  logic [IW:0]   steps_r;
  logic [PW-1:0] res_r;
  logic [1:0]    st_r;

  // Registered read ports.
  logic [KW-1:0] key_q;
  logic [IW-1:0] first_q, last_q, link_q, pslot_q;
  logic [IW-1:0] kaddr, saddr, laddr;

  logic pid_ok;
  assign pid_ok = ({{(32-PW){1'b0}}, pid_r} < NUM_PROCS);

  always_ff @(posedge clk) begin
    key_q   <= key_mem[kaddr];
    first_q <= first_mem[saddr];
    last_q  <= last_mem[saddr];
    link_q  <= link_mem[laddr];
    pslot_q <= pslot_mem[pidx_r];
  end

  // Key scan walks slots one per cycle during S_RD; walk uses link port.
  assign kaddr = scan_r[IW-1:0];
  assign laddr = (state_r == S_WALK || state_r == S_WWAIT) ? cur_r : first_r;

  always_comb begin
    saddr = slot_r;
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_valid_r <= '0;
      proc_wait_r  <= '0;
      out_valid    <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start) begin
          op_r         <= in_operation;
          key_r        <= in_sem_key;
          pid_r        <= in_process_id;
          pidx_r       <= IW'(in_process_id);
          scan_r       <= '0;
          hit_r        <= 1'b0;
          free_found_r <= 1'b0;
          state_r      <= S_RD;
        end
        S_RD: begin
          // One slot compared per cycle; key_q is the registered read at scan_r, so it matches scan_r - 1.
          if (scan_r != '0) begin
            if (!hit_r && slot_valid_r[scan_r[IW-1:0] - 1'b1] && key_q == key_r) begin
              hit_r  <= 1'b1;
              slot_r <= scan_r[IW-1:0] - 1'b1;
            end
            if (!free_found_r && !slot_valid_r[scan_r[IW-1:0] - 1'b1]) begin
              free_found_r <= 1'b1;
              free_r       <= scan_r[IW-1:0] - 1'b1;
            end
          end
          if (op_r == swqt_pkg::OP_OUT) begin
            // Slot comes from the process table instead of the key.
            if (scan_r == '0) scan_r <= scan_r + 1'b1;
            else begin
              slot_r  <= pslot_q;
              state_r <= S_EVAL;
              scan_r  <= '0;
            end
          end else if (scan_r == (IW+1)'(NUM_PROCS)) begin
            state_r <= S_EVAL;
            scan_r  <= '0;
          end else scan_r <= scan_r + 1'b1;
        end
        S_EVAL: begin
          // first_q/last_q are registered reads; they are valid the cycle after slot_r settles.
          if (scan_r == '0) scan_r <= scan_r + 1'b1;
          else begin
            first_r <= first_q;
            last_r  <= last_q;
            res_r   <= '0;
            st_r    <= swqt_pkg::ST_OK;
            state_r <= S_DONE;
            case (op_r) inside
              swqt_pkg::OP_BLOCK: begin
                if (!pid_ok) st_r <= swqt_pkg::ST_NOTFND;
                else if (proc_wait_r[pidx_r]) st_r <= swqt_pkg::ST_BLOCKED;
                else if (hit_r) begin
                  link_mem[last_q]   <= pidx_r;
                  last_mem[slot_r]   <= pidx_r;
                  proc_wait_r[pidx_r] <= 1'b1;
                  pslot_mem[pidx_r]  <= slot_r;
                end else if (!free_found_r) st_r <= swqt_pkg::ST_NOFREE;
                else begin
                  slot_valid_r[free_r] <= 1'b1;
                  key_mem[free_r]      <= key_r;
                  first_mem[free_r]    <= pidx_r;
                  last_mem[free_r]     <= pidx_r;
                  proc_wait_r[pidx_r]  <= 1'b1;
                  pslot_mem[pidx_r]    <= free_r;
                end
              end
              swqt_pkg::OP_UNBLOCK, swqt_pkg::OP_HEAD: begin
                if (!hit_r) st_r <= swqt_pkg::ST_NOTFND;
                else begin
                  res_r <= PW'(first_q);
                  if (op_r == swqt_pkg::OP_UNBLOCK) begin
                    proc_wait_r[first_q] <= 1'b0;
                    if (first_q == last_q) slot_valid_r[slot_r] <= 1'b0;
                    else begin
                      cur_r   <= first_q;
                      state_r <= S_WWAIT; // fetch link of head
                    end
                  end
                end
              end
              default: begin
                if (!pid_ok || !proc_wait_r[pidx_r] || !slot_valid_r[slot_r])
                  st_r <= swqt_pkg::ST_NOTFND;
                else begin
                  cur_r   <= first_q;
                  steps_r <= '0;
                  state_r <= S_WALK;
                end
              end
            endcase
            scan_r <= '0;
          end
        end
        S_WWAIT: begin
          // Link read of cur_r issued; scan_r marks when the registered link_q is ready.
          if (scan_r == '0) scan_r <= scan_r + 1'b1;
          else begin
            first_mem[slot_r] <= link_q;
            state_r <= S_DONE;
          end
        end
        S_WALK: begin
          // Each step needs one registered link read; scan_r[0] marks data ready.
          if (scan_r == '0) scan_r <= scan_r + 1'b1;
          else begin
            scan_r <= '0;
            if (cur_r == pidx_r) begin
              if (pidx_r == first_r) begin
                if (pidx_r == last_r) slot_valid_r[slot_r] <= 1'b0;
                else first_mem[slot_r] <= link_q;
              end else begin
                link_mem[prev_r] <= link_q;
                if (pidx_r == last_r) last_mem[slot_r] <= prev_r;
              end
              proc_wait_r[pidx_r] <= 1'b0;
              res_r   <= pid_r;
              state_r <= S_DONE;
            end else if (cur_r == last_r || steps_r == (IW+1)'(NUM_PROCS - 1)) begin
              st_r    <= swqt_pkg::ST_NOTFND;
              state_r <= S_DONE;
            end else begin
              prev_r  <= cur_r;
              cur_r   <= link_q;
              steps_r <= steps_r + 1'b1;
            end
          end
        end
        S_DONE: begin
          out_valid          <= 1'b1;
          out_result_process <= (st_r == swqt_pkg::ST_OK) ? res_r : '0;
          out_status         <= st_r;
          state_r            <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != swqt_pkg::ST_OK) |-> out_result_process == '0)
    else $error("nonzero process with error status");
`endif

endmodule

### tb/semaphore_wait_queue_table_tb.sv
// Self-checking testbench for the semaphore wait queue table, with a behavioural predictor.
module semaphore_wait_queue_table_tb;

  localparam int NP = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int KW = swqt_pkg::KEY_W;
  localparam int PW = swqt_pkg::PID_W;

  typedef struct packed {
    logic [PW-1:0] proc_id;
    logic [1:0]    status;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0] in_operation = swqt_pkg::OP_HEAD;
  logic [KW-1:0] in_sem_key = '0;
  logic [PW-1:0] in_process_id = '0;
  logic busy, out_valid;
  logic [PW-1:0] out_result_process;
  logic [1:0] out_status;

  // Predictor state: the table as the block should hold it.
  logic          sv_valid [NP];
  logic [KW-1:0] sv_key   [NP];
  logic [3:0]    q_first  [NP];
  logic [3:0]    q_last   [NP];
  logic [3:0]    nxt      [NP];
  logic          waiting  [NP];
  logic [3:0]    pslot    [NP];

  outcome_t pending_outcomes[$];
  int mismatches = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int idle_cycles = 0;
  int op_seen [4] = '{0, 0, 0, 0};
  int status_seen [4] = '{0, 0, 0, 0};
  logic [KW-1:0] key_pool [6];

  semaphore_wait_queue_table #(.NUM_PROCS(NP)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_sem_key(in_sem_key), .in_process_id(in_process_id),
    .out_valid(out_valid), .out_result_process(out_result_process), .out_status(out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int find_key(logic [KW-1:0] k);
    for (int s = 0; s < NP; s++) if (sv_valid[s] && sv_key[s] == k) return s;
    return -1;
  endfunction

  function automatic outcome_t predict_table(logic [1:0] op, logic [KW-1:0] k,
                                             logic [3:0] p);
    outcome_t r;
    int s;
    logic [3:0] cur, prv, h, ps;
    logic found;
    r = '{proc_id: '0, status: swqt_pkg::ST_OK};
    case (op)
      swqt_pkg::OP_BLOCK: begin
        if (waiting[p]) r.status = swqt_pkg::ST_BLOCKED;
        else begin
          s = find_key(k);
          if (s >= 0) begin
            nxt[q_last[s]] = p;
            q_last[s] = p;
          end else begin
            for (int i = NP - 1; i >= 0; i--) if (!sv_valid[i]) s = i;
            if (s < 0) r.status = swqt_pkg::ST_NOFREE;
            else begin
              sv_valid[s] = 1'b1;
              sv_key[s] = k;
              q_first[s] = p;
              q_last[s] = p;
            end
          end
          if (r.status == swqt_pkg::ST_OK) begin
            waiting[p] = 1'b1;
            pslot[p] = s[3:0];
          end
        end
      end
      swqt_pkg::OP_UNBLOCK: begin
        s = find_key(k);
        if (s < 0) r.status = swqt_pkg::ST_NOTFND;
        else begin
          h = q_first[s];
          waiting[h] = 1'b0;
          if (h == q_last[s]) sv_valid[s] = 1'b0;
          else q_first[s] = nxt[h];
          r.proc_id = h;
        end
      end
      swqt_pkg::OP_OUT: begin
        found = 1'b0;
        prv = '0;
        ps = pslot[p];
        if (waiting[p] && sv_valid[ps]) begin
          cur = q_first[ps];
          for (int n = 0; n < NP; n++) begin
            if (cur == p) begin
              found = 1'b1;
              break;
            end
            if (cur == q_last[ps]) break;
            prv = cur;
            cur = nxt[cur];
          end
        end
        if (!found) r.status = swqt_pkg::ST_NOTFND;
        else begin
          if (p == q_first[ps]) begin
            if (p == q_last[ps]) sv_valid[ps] = 1'b0;
            else q_first[ps] = nxt[p];
          end else begin
            nxt[prv] = nxt[p];
            if (p == q_last[ps]) q_last[ps] = prv;
          end
          waiting[p] = 1'b0;
          r.proc_id = p;
        end
      end
      default: begin
        s = find_key(k);
        if (s < 0) r.status = swqt_pkg::ST_NOTFND;
        else r.proc_id = q_first[s];
      end
    endcase
    if (r.status != swqt_pkg::ST_OK) r.proc_id = '0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Sends one beat after a given or random gap and records its predicted outcome.
  task automatic send_request(logic [1:0] op, logic [KW-1:0] k, logic [3:0] p,
                              int gap = -1);
    int wait_n;
    wait_n = (gap < 0) ? $urandom_range(15) : gap;
    if ($urandom_range(3) == 0 && gap < 0) wait_n = 0;
    if (wait_n > 0) begin
      start <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    in_operation <= op;
    in_sem_key <= k;
    in_process_id <= p;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_outcomes.push_back(predict_table(op, k, p));
    op_seen[op]++;
    beats_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result beats outstanding", 0, 1);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", int'(out_status), int'(want.status));
        if (out_result_process !== want.proc_id)
          report_mismatch("result_process", int'(out_result_process), int'(want.proc_id));
        status_seen[want.status]++;
        beats_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_outcomes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic drain_outcomes();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(swqt_pkg::OP_HEAD, 31'd1, 4'd0);
    send_request(swqt_pkg::OP_UNBLOCK, 31'h7fffffff, 4'd0);
    send_request(swqt_pkg::OP_OUT, 31'd0, 4'd15);
    send_request(swqt_pkg::OP_BLOCK, 31'h7fffffff, 4'd0);
    send_request(swqt_pkg::OP_BLOCK, 31'h7fffffff, 4'd15);
    send_request(swqt_pkg::OP_BLOCK, 31'd0, 4'd15);
    send_request(swqt_pkg::OP_BLOCK, 31'd0, 4'd7);
    send_request(swqt_pkg::OP_HEAD, 31'h7fffffff, 4'd3);
    send_request(swqt_pkg::OP_BLOCK, 31'h7fffffff, 4'd9);
    send_request(swqt_pkg::OP_OUT, 31'h5555, 4'd15);
    send_request(swqt_pkg::OP_OUT, 31'h1, 4'd15);
    send_request(swqt_pkg::OP_UNBLOCK, 31'h7fffffff, 4'd0);
    send_request(swqt_pkg::OP_HEAD, 31'h7fffffff, 4'd0);
    send_request(swqt_pkg::OP_OUT, 31'h0, 4'd9);
    send_request(swqt_pkg::OP_HEAD, 31'h7fffffff, 4'd0);
    send_request(swqt_pkg::OP_UNBLOCK, 31'd0, 4'd0);
    // Fill every descriptor with its own key back to back, then remove each process again.
    for (int i = 0; i < NP; i++)
      send_request(swqt_pkg::OP_BLOCK, KW'(256 + i), i[3:0], 0);
    for (int i = 0; i < NP; i++) send_request(swqt_pkg::OP_OUT, 31'd0, i[3:0], 0);
    drain_outcomes();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < NP; i++)
      send_request(swqt_pkg::OP_BLOCK, {16'h2a2a, 11'd0, i[3:0]}, i[3:0]);
    send_request(swqt_pkg::OP_UNBLOCK, {16'h2a2a, 15'd3}, 4'd0);
    send_request(swqt_pkg::OP_BLOCK, 31'h7ffffffe, 4'd3);
    send_request(swqt_pkg::OP_BLOCK, 31'h12345, 4'd3);
    for (int i = 0; i < NP; i++) send_request(swqt_pkg::OP_OUT, 31'd0, i[3:0]);
    drain_outcomes();
  endtask

  // Mostly a few shared keys so queues grow long; a few random keys for noise.
  task automatic test_random(int count);
    logic [1:0] op;
    logic [KW-1:0] k;
    for (int i = 0; i < 6; i++) key_pool[i] = KW'($urandom());
    for (int n = 0; n < count; n++) begin
      op = $urandom_range(9) < 4 ? swqt_pkg::OP_BLOCK : 2'($urandom_range(3));
      k = $urandom_range(9) == 0 ? KW'($urandom()) : key_pool[$urandom_range(5)];
      send_request(op, k, 4'($urandom_range(15)));
      if (n == count / 2) drain_outcomes();
    end
  endtask

  initial begin
    for (int i = 0; i < NP; i++) begin
      sv_valid[i] = 1'b0;
      waiting[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(1560);
    drain_outcomes();
    repeat (60) @(posedge clk);
    $display("%0d beats checked: block %0d, unblock %0d, out %0d, head %0d.", beats_checked,
             op_seen[swqt_pkg::OP_BLOCK], op_seen[swqt_pkg::OP_UNBLOCK],
             op_seen[swqt_pkg::OP_OUT], op_seen[swqt_pkg::OP_HEAD]);
    $display("Statuses seen: ok %0d, not found %0d, no free %0d, already blocked %0d.",
             status_seen[swqt_pkg::ST_OK], status_seen[swqt_pkg::ST_NOTFND],
             status_seen[swqt_pkg::ST_NOFREE], status_seen[swqt_pkg::ST_BLOCKED]);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
